// File: rtl/core/bba_pkg.sv
// Shared widths, codes and state encoding for the bitmap block allocator.
`default_nettype none

package bba_pkg;

    localparam int DEF_NUM_BLOCKS = 4096;
    localparam int DEF_MAX_RUN    = 16;

    localparam int WORD_W     = 64;
    localparam int TOTAL_W    = 13;
    localparam int INDEX_W    = 12;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int COMMAND_W  = 2;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_MARK    = 2'd2
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BIT_RD,
        S_BIT_WR,
        S_SCAN,
        S_RB_RD,
        S_RB_OCC,
        S_RB_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/bba_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bitmap_block_allocator_core.sv
// Top level of the first-fit bitmap block allocator.
//
//   channel  direction  signals                                    handshake
//   in       input      command, block_index, block_count          in_valid / in_ready
//   out      output     granted_block, status, last                out_valid / out_ready
//   cfg      input      cfg_data (block_total)                     cfg_write
//
// Reset starts a clearing pass over every occupancy RAM word; no command is taken until it ends.
// Release or mark rewrites one bitmap bit; range errors and oversized runs respond directly.
// Allocate: each block is found by scanning bitmap words from the word of the previous hit (the
// occupancy RAM read port, one word a cycle); each result is then read from the run list RAM.
// A failed run rolls back every block already taken and reports no space.
// Commands are taken one at a time; a result waiting in the output register does not stall intake.
`default_nettype none

module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS,
    parameter int MAX_RUN    = bba_pkg::DEF_MAX_RUN
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [bba_pkg::TOTAL_W-1:0]    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [bba_pkg::COMMAND_W-1:0]  command,
    input  wire logic [bba_pkg::INDEX_W-1:0]    block_index,
    input  wire logic [bba_pkg::COUNT_W-1:0]    block_count,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bba_pkg::INDEX_W-1:0]         granted_block,
    output logic [bba_pkg::STATUS_W-1:0]        status,
    output logic                                last
);

    import bba_pkg::*;

    localparam int WORD_COUNT = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int LW  = AW + 1;
    localparam int IW  = $clog2(NUM_BLOCKS);
    localparam int TW  = IW + 1;
    localparam int CW  = (TW > TOTAL_W) ? TW : TOTAL_W;
    localparam int XW  = CW + 1;
    localparam int RW  = $clog2(MAX_RUN + 1);
    localparam int RA  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int KW  = ((RW > COUNT_W) ? RW : COUNT_W) + 1;

    state_t               state_reg, state_next;
    logic [TOTAL_W-1:0]   block_total_reg;
    logic [COMMAND_W-1:0] cmd_reg, cmd_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [RW-1:0]        fill_reg, fill_next;
    logic [RW-1:0]        ptr_reg, ptr_next;
    logic [LW-1:0]        rd_word_reg, rd_word_next;
    logic [AW-1:0]        chk_word_reg, chk_word_next;
    logic                 data_vld_reg, data_vld_next;
    logic [AW-1:0]        clr_reg, clr_next;
    status_t              resp_status_reg, resp_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]   out_block_reg, out_block_next;
    status_t              out_status_reg, out_status_next;
    logic                 out_last_reg, out_last_next;

    logic              occ_we, occ_re;
    logic [AW-1:0]     occ_waddr, occ_raddr;
    logic [WORD_W-1:0] occ_wdata, occ_rdata;
    logic              run_we, run_re;
    logic [RA-1:0]     run_waddr, run_raddr;
    logic [IW-1:0]     run_wdata, run_rdata;

    logic [CW-1:0]     total_eff;
    logic [XW-1:0]     word_limit;
    logic [WORD_W-1:0] valid_mask, free_bits, low_bit;
    logic [5:0]        hit_pos;
    logic              hit, more;
    logic [CW-1:0]     idx_ext, run_ext;
    logic [IW-1:0]     found_blk;
    logic              slot_free;

    bba_ram #(.WIDTH(WORD_W), .DEPTH(WORD_COUNT), .ADDR_W(AW)) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .re    (occ_re),
        .raddr (occ_raddr),
        .rdata (occ_rdata)
    );

    bba_ram #(.WIDTH(IW), .DEPTH(MAX_RUN), .ADDR_W(RA)) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (run_waddr),
        .wdata (run_wdata),
        .re    (run_re),
        .raddr (run_raddr),
        .rdata (run_rdata)
    );

    assign total_eff  = (XW'(block_total_reg) >= XW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                                   : CW'(block_total_reg);
    assign word_limit = (XW'(total_eff) + XW'(WORD_W - 1)) >> 6;
    assign more       = XW'(rd_word_reg) < word_limit;
    assign idx_ext    = CW'(idx_reg);
    assign run_ext    = CW'(run_rdata);
    assign valid_mask = (XW'(chk_word_reg) == XW'(total_eff >> 6))
                        ? ((WORD_W'(1) << total_eff[5:0]) - WORD_W'(1)) : '1;
    assign free_bits  = ~occ_rdata & valid_mask;
    assign low_bit    = free_bits & (~free_bits + WORD_W'(1));
    assign hit        = data_vld_reg && (|free_bits);
    assign found_blk  = IW'({chk_word_reg, hit_pos});
    assign slot_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        hit_pos = '0;
        for (int k = 0; k < 6; k++)
        begin
            for (int j = 0; j < WORD_W; j++)
            begin
                if (((j >> k) & 1) != 0)
                begin
                    hit_pos[k] = hit_pos[k] | low_bit[j];
                end
            end
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign granted_block = out_block_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            block_total_reg <= TOTAL_RESET;
            fill_reg        <= '0;
            ptr_reg         <= '0;
            rd_word_reg     <= '0;
            data_vld_reg    <= 1'b0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            rd_word_reg   <= rd_word_next;
            data_vld_reg  <= data_vld_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                block_total_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        idx_reg         <= idx_next;
        cnt_reg         <= cnt_next;
        chk_word_reg    <= chk_word_next;
        resp_status_reg <= resp_status_next;
        out_block_reg   <= out_block_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        fill_next        = fill_reg;
        ptr_next         = ptr_reg;
        rd_word_next     = rd_word_reg;
        chk_word_next    = chk_word_reg;
        data_vld_next    = 1'b0;
        clr_next         = clr_reg;
        resp_status_next = resp_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_block_next   = out_block_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;

        occ_we    = 1'b0;
        occ_waddr = '0;
        occ_wdata = '0;
        occ_re    = 1'b0;
        occ_raddr = '0;
        run_we    = 1'b0;
        run_waddr = fill_reg[RA-1:0];
        run_wdata = found_blk;
        run_re    = 1'b0;
        run_raddr = ptr_reg[RA-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                occ_we    = 1'b1;
                occ_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(WORD_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    idx_next = block_index;
                    cnt_next = block_count;
                    unique case (command) inside
                        CMD_ALLOC:
                        begin
                            if (KW'(block_count) > KW'(MAX_RUN))
                            begin
                                resp_status_next = STAT_RANGE;
                                state_next       = S_RESP;
                            end
                            else if (block_count != '0)
                            begin
                                fill_next    = '0;
                                rd_word_next = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        CMD_RELEASE, CMD_MARK:
                        begin
                            if (CW'(block_index) >= total_eff)
                            begin
                                resp_status_next = STAT_RANGE;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                state_next = S_BIT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_BIT_RD:
            begin
                occ_re     = 1'b1;
                occ_raddr  = idx_ext[6 +: AW];
                state_next = S_BIT_WR;
            end

            S_BIT_WR:
            begin
                occ_we    = 1'b1;
                occ_waddr = idx_ext[6 +: AW];
                if (cmd_reg == CMD_MARK)
                begin
                    occ_wdata = occ_rdata | (WORD_W'(1) << idx_reg[5:0]);
                end
                else
                begin
                    occ_wdata = occ_rdata & ~(WORD_W'(1) << idx_reg[5:0]);
                end
                resp_status_next = STAT_OK;
                state_next       = S_RESP;
            end

            S_SCAN:
            begin
                occ_re        = more;
                occ_raddr     = rd_word_reg[AW-1:0];
                data_vld_next = more;
                chk_word_next = rd_word_reg[AW-1:0];
                if (more)
                begin
                    rd_word_next = rd_word_reg + LW'(1);
                end
                if (hit)
                begin
                    occ_we        = 1'b1;
                    occ_waddr     = chk_word_reg;
                    occ_wdata     = occ_rdata | low_bit;
                    run_we        = 1'b1;
                    fill_next     = fill_reg + RW'(1);
                    data_vld_next = 1'b0;
                    rd_word_next  = LW'(chk_word_reg);
                    if (KW'(fill_reg + RW'(1)) == KW'(cnt_reg))
                    begin
                        ptr_next   = '0;
                        state_next = S_OUT_RD;
                    end
                end
                else if (!more)
                begin
                    ptr_next = '0;
                    if (fill_reg == '0)
                    begin
                        resp_status_next = STAT_NOSPACE;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        state_next = S_RB_RD;
                    end
                end
            end

            S_RB_RD:
            begin
                run_re     = 1'b1;
                state_next = S_RB_OCC;
            end

            S_RB_OCC:
            begin
                occ_re     = 1'b1;
                occ_raddr  = run_ext[6 +: AW];
                state_next = S_RB_WR;
            end

            S_RB_WR:
            begin
                occ_we    = 1'b1;
                occ_waddr = run_ext[6 +: AW];
                occ_wdata = occ_rdata & ~(WORD_W'(1) << run_ext[5:0]);
                ptr_next  = ptr_reg + RW'(1);
                if (ptr_reg + RW'(1) == fill_reg)
                begin
                    fill_next        = '0;
                    resp_status_next = STAT_NOSPACE;
                    state_next       = S_RESP;
                end
                else
                begin
                    state_next = S_RB_RD;
                end
            end

            S_OUT_RD:
            begin
                run_re     = 1'b1;
                state_next = S_OUT_LD;
            end

            S_OUT_LD:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_block_next  = run_ext[INDEX_W-1:0];
                    out_status_next = STAT_OK;
                    out_last_next   = (ptr_reg + RW'(1) == fill_reg);
                    ptr_next        = ptr_reg + RW'(1);
                    if (ptr_reg + RW'(1) == fill_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OUT_RD;
                    end
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_block_next  = '0;
                    out_status_next = resp_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
